// ----- hw/rtl/tqbp_pkg.sv -----
package tqbp_pkg;

    // Entry type codes and the phrase operator code.
    localparam logic [7:0] QI_VAL     = 8'd1;
    localparam logic [7:0] QI_OPR     = 8'd2;
    localparam logic [7:0] OPC_PHRASE = 8'd4;

    // Length word that marks a null record.
    localparam logic [31:0] NULL_LENGTH = 32'hFFFF_FFFF;

    // Smallest legal record length: the body always holds the entry count.
    localparam logic [31:0] MIN_LENGTH = 32'd4;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_LEN     = 4'd0,
        PH_COUNT   = 4'd1,
        PH_TYPE    = 4'd2,
        PH_WEIGHT  = 4'd3,
        PH_PREFIX  = 4'd4,
        PH_OPERAND = 4'd5,
        PH_OPER    = 4'd6,
        PH_DHI     = 4'd7,
        PH_DLO     = 4'd8,
        PH_SKIP    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        EV_NULL      = 3'd0,
        EV_START     = 3'd1,
        EV_CHAR      = 3'd2,
        EV_VALUE_END = 3'd3,
        EV_OPERATOR  = 3'd4,
        EV_OTHER     = 3'd5,
        EV_REC_END   = 3'd6,
        EV_MALFORMED = 3'd7
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [30:0]        entry_count;
        logic [7:0]         entry_type;
        logic [7:0]         weight;
        logic [7:0]         prefix_flag;
        logic [7:0]         operand_char;
        logic [7:0]         operator_code;
        logic signed [15:0] distance;
        logic               last_of_step;
    } t_result;

    // Results produced by one accepted byte: zero, one or two of them.
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

endpackage

// ----- hw/rtl/text_query_binary_parser.sv -----
// Byte-serial parser for length-prefixed binary full-text query records.
// The slave stream takes one raw byte per item on s_axis_tdata. The master
// stream returns one parse event per item: m_axis_tuser carries the event
// code, m_axis_tdata the entry fields, and m_axis_tlast marks the final event
// caused by a given input byte (a byte causes zero, one or two events).
// Each byte is decoded by a small state register and short decode logic in
// the cycle it is accepted; its events are registered in a four-entry result
// queue, from which the master side offers them in order.
// Throughput is one byte per cycle while the queue has room for two events;
// a byte is taken only then, so s_axis_tready drops when three or more
// events wait. A stalled receiver therefore stops the input as soon as
// three events are queued, which takes at most three more bytes that cause
// events; bytes that cause no event are taken until then. Nothing is lost
// or reordered. The synchronous active-low reset empties the queue and
// returns the parser to waiting for the first byte of a record length.
module text_query_binary_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [30:0] entry_count, [38:31] entry_type, [46:39] weight,
    // [54:47] prefix_flag, [62:55] operand_char, [70:63] operator_code,
    // [86:71] distance, [87] zero pad
    output logic [87:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    output logic        m_axis_tlast    // last_of_step
);

    logic               w_accept;
    tqbp_pkg::t_push    w_push;
    tqbp_pkg::t_result  w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    tqbp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_byte  (s_axis_tdata),
        .o_push  (w_push)
    );

    tqbp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {1'b0, w_out.distance, w_out.operator_code, w_out.operand_char,
                           w_out.prefix_flag, w_out.weight, w_out.entry_type,
                           w_out.entry_count};
    assign m_axis_tuser = w_out.event_res;
    assign m_axis_tlast = w_out.last_of_step;

endmodule

// ----- hw/rtl/tqbp_parser.sv -----
module tqbp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    output tqbp_pkg::t_push      o_push
);

    tqbp_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_idx, n_idx;
    logic [23:0]      r_shift, n_shift;
    logic [30:0]      r_bytes_left, n_bytes_left;
    logic [30:0]      r_entries, n_entries;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_weight, n_weight;
    logic [7:0]       r_prefix, n_prefix;
    logic [7:0]       r_operator, n_operator;
    logic [7:0]       r_dist_hi, n_dist_hi;

    logic [31:0]        w_word;
    logic [30:0]        w_ent_dec;
    logic               w_prim_v;
    tqbp_pkg::t_result  w_prim;
    logic               w_end_v;
    tqbp_pkg::t_result  w_end;

    assign w_word    = {r_shift, i_byte};
    assign w_ent_dec = r_entries - 31'd1;

    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_entries    = r_entries;
        n_type       = r_type;
        n_weight     = r_weight;
        n_prefix     = r_prefix;
        n_operator   = r_operator;
        n_dist_hi    = r_dist_hi;
        w_prim_v     = 1'b0;
        w_prim       = '0;
        w_end_v      = 1'b0;
        w_end        = '0;

        if (i_valid) begin
            if (r_phase == tqbp_pkg::PH_LEN) begin
                n_idx   = r_idx + 2'd1;
                n_shift = {r_shift[15:0], i_byte};
                if (r_idx == 2'd3) begin
                    n_shift = '0;
                    if (w_word == tqbp_pkg::NULL_LENGTH) begin
                        w_prim_v           = 1'b1;
                        w_prim.event_res   = tqbp_pkg::EV_NULL;
                    end else if (w_word[31] || (w_word < tqbp_pkg::MIN_LENGTH)) begin
                        w_prim_v           = 1'b1;
                        w_prim.event_res   = tqbp_pkg::EV_MALFORMED;
                    end else begin
                        n_bytes_left = w_word[30:0];
                        n_phase      = tqbp_pkg::PH_COUNT;
                    end
                end
            end else begin
                n_bytes_left = r_bytes_left - 31'd1;
                case (r_phase)
                    tqbp_pkg::PH_COUNT: begin
                        n_idx   = r_idx + 2'd1;
                        n_shift = {r_shift[15:0], i_byte};
                        if (r_idx == 2'd3) begin
                            n_shift  = '0;
                            w_prim_v = 1'b1;
                            if (w_word[31]) begin
                                w_prim.event_res = tqbp_pkg::EV_MALFORMED;
                                n_phase          = tqbp_pkg::PH_LEN;
                            end else begin
                                n_entries          = w_word[30:0];
                                w_prim.event_res   = tqbp_pkg::EV_START;
                                w_prim.entry_count = w_word[30:0];
                                n_phase = (w_word[30:0] != '0) ? tqbp_pkg::PH_TYPE
                                                               : tqbp_pkg::PH_SKIP;
                            end
                        end
                    end
                    tqbp_pkg::PH_TYPE: begin
                        n_type = i_byte;
                        if (i_byte == tqbp_pkg::QI_VAL) begin
                            n_phase = tqbp_pkg::PH_WEIGHT;
                        end else if (i_byte == tqbp_pkg::QI_OPR) begin
                            n_phase = tqbp_pkg::PH_OPER;
                        end else begin
                            w_prim_v          = 1'b1;
                            w_prim.event_res  = tqbp_pkg::EV_OTHER;
                            w_prim.entry_type = i_byte;
                            n_entries = w_ent_dec;
                            n_phase   = (w_ent_dec != '0) ? tqbp_pkg::PH_TYPE
                                                          : tqbp_pkg::PH_SKIP;
                        end
                    end
                    tqbp_pkg::PH_WEIGHT: begin
                        n_weight = i_byte;
                        n_phase  = tqbp_pkg::PH_PREFIX;
                    end
                    tqbp_pkg::PH_PREFIX: begin
                        n_prefix = i_byte;
                        n_phase  = tqbp_pkg::PH_OPERAND;
                    end
                    tqbp_pkg::PH_OPERAND: begin
                        w_prim_v           = 1'b1;
                        w_prim.entry_type  = r_type;
                        w_prim.weight      = r_weight;
                        w_prim.prefix_flag = r_prefix;
                        if (i_byte != 8'd0) begin
                            w_prim.event_res    = tqbp_pkg::EV_CHAR;
                            w_prim.operand_char = i_byte;
                        end else begin
                            w_prim.event_res = tqbp_pkg::EV_VALUE_END;
                            n_entries = w_ent_dec;
                            n_phase   = (w_ent_dec != '0) ? tqbp_pkg::PH_TYPE
                                                          : tqbp_pkg::PH_SKIP;
                        end
                    end
                    tqbp_pkg::PH_OPER: begin
                        n_operator = i_byte;
                        if (i_byte == tqbp_pkg::OPC_PHRASE) begin
                            n_phase = tqbp_pkg::PH_DHI;
                        end else begin
                            w_prim_v             = 1'b1;
                            w_prim.event_res     = tqbp_pkg::EV_OPERATOR;
                            w_prim.entry_type    = r_type;
                            w_prim.operator_code = i_byte;
                            n_entries = w_ent_dec;
                            n_phase   = (w_ent_dec != '0) ? tqbp_pkg::PH_TYPE
                                                          : tqbp_pkg::PH_SKIP;
                        end
                    end
                    tqbp_pkg::PH_DHI: begin
                        n_dist_hi = i_byte;
                        n_phase   = tqbp_pkg::PH_DLO;
                    end
                    tqbp_pkg::PH_DLO: begin
                        w_prim_v             = 1'b1;
                        w_prim.event_res     = tqbp_pkg::EV_OPERATOR;
                        w_prim.entry_type    = r_type;
                        w_prim.operator_code = r_operator;
                        w_prim.distance      = $signed({r_dist_hi, i_byte});
                        n_entries = w_ent_dec;
                        n_phase   = (w_ent_dec != '0) ? tqbp_pkg::PH_TYPE
                                                      : tqbp_pkg::PH_SKIP;
                    end
                    default: begin
                    end
                endcase

                // The last body byte closes the record, cleanly only if all
                // entries were complete.
                if ((n_phase != tqbp_pkg::PH_LEN) && (r_bytes_left == 31'd1)) begin
                    w_end_v         = 1'b1;
                    w_end.event_res = (n_phase == tqbp_pkg::PH_SKIP) ?
                                      tqbp_pkg::EV_REC_END : tqbp_pkg::EV_MALFORMED;
                    n_phase = tqbp_pkg::PH_LEN;
                    n_idx   = 2'd0;
                    n_shift = '0;
                end else if (n_phase == tqbp_pkg::PH_LEN) begin
                    n_idx   = 2'd0;
                    n_shift = '0;
                end
            end
        end
    end

    // Pack up to two results; in a pair, the record-end result comes second.
    always_comb begin
        o_push       = '0;
        o_push.count = {1'b0, w_prim_v} + {1'b0, w_end_v};
        o_push.slot0 = w_prim_v ? w_prim : w_end;
        o_push.slot0.last_of_step = !(w_prim_v && w_end_v);
        o_push.slot1 = w_end;
        o_push.slot1.last_of_step = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tqbp_pkg::PH_LEN;
            r_idx        <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_entries    <= '0;
            r_type       <= '0;
            r_weight     <= '0;
            r_prefix     <= '0;
            r_operator   <= '0;
            r_dist_hi    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_entries    <= n_entries;
            r_type       <= n_type;
            r_weight     <= n_weight;
            r_prefix     <= n_prefix;
            r_operator   <= n_operator;
            r_dist_hi    <= n_dist_hi;
        end
    end

    // A pair of results only occurs when a record closes.
    a_pair_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |->
        ((o_push.slot1.event_res == tqbp_pkg::EV_REC_END) ||
         (o_push.slot1.event_res == tqbp_pkg::EV_MALFORMED)))
        else $error("second result is not a record close");

    // Body phases are never entered without a body byte budget.
    a_body_has_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tqbp_pkg::PH_LEN) |-> (r_bytes_left != '0))
        else $error("body phase with no bytes left");

endmodule

// ----- hw/rtl/tqbp_out_queue.sv -----
module tqbp_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tqbp_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output tqbp_pkg::t_result   o_data
);

    tqbp_pkg::t_result                  r_mem [tqbp_pkg::QUEUE_DEPTH];
    logic [tqbp_pkg::QUEUE_AW-1:0]      r_wr, n_wr;
    logic [tqbp_pkg::QUEUE_AW-1:0]      r_rd, n_rd;
    logic [tqbp_pkg::QUEUE_CW-1:0]      r_count, n_count;
    logic [tqbp_pkg::QUEUE_AW-1:0]      w_wr1;
    logic                               w_pop;

    assign w_wr1   = r_wr + 1'b1;
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    // Room for a whole pair is needed before another byte is taken.
    assign o_room  = (r_count <= tqbp_pkg::QUEUE_CW'(tqbp_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + i_push.count[tqbp_pkg::QUEUE_AW-1:0];
        n_rd    = r_rd + tqbp_pkg::QUEUE_AW'(w_pop);
        n_count = r_count + tqbp_pkg::QUEUE_CW'(i_push.count)
                          - tqbp_pkg::QUEUE_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr1] <= i_push.slot1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tqbp_pkg::QUEUE_CW'(tqbp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (i_push.count == 2'd0)) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drain the queue");

endmodule

// ----- tb/text_query_binary_parser_tb.sv -----
`timescale 1ns / 100ps

// Stream-level check of the query record parser. A queue of raw bytes is
// built up front: a short directed run through the record formats and the
// error paths, then random records that are mostly well formed. A clocked
// driver feeds the bytes; every accepted item is run through a behavioral
// parser in this module, which queues the events the block must produce. A
// clocked monitor pops the oldest expected event for every accepted result
// and compares it field by field.
module text_query_binary_parser_tb;

    localparam int RANDOM_BYTES = 1400;
    localparam int IDLE_PCT     = 26;
    // Both sides run without gaps inside this window of cycles.
    localparam int CALM_FROM    = 1000;
    localparam int CALM_TO      = 1600;
    // The receiver stops for a long stretch once this many bytes went in.
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    text_query_binary_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Bytes still to be offered, and the record body under construction.
    logic [7:0] byte_stream[$];
    logic [7:0] rec_body[$];
    int         total_bytes    = 0;
    int         bytes_accepted = 0;

    // Events that the parser owes, oldest first.
    tqbp_pkg::t_result want_events[$];
    int         errors    = 0;
    int         cycle_cnt = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;

    // Parser state as the block should hold it.
    tqbp_pkg::t_phase pr_phase;
    logic [1:0]  pr_byte_idx;
    logic [31:0] pr_rec_len;
    logic [31:0] pr_consumed;
    logic [31:0] pr_shift;
    logic [30:0] pr_left;
    logic [7:0]  pr_type;
    logic [7:0]  pr_weight;
    logic [7:0]  pr_prefix;
    logic [7:0]  pr_oper;
    logic [7:0]  pr_dist_hi;

    function automatic tqbp_pkg::t_result blank_event(input tqbp_pkg::t_event ev);
        tqbp_pkg::t_result r;
        r = '0;
        r.event_res = ev;
        return r;
    endfunction

    function automatic tqbp_pkg::t_result value_event(input tqbp_pkg::t_event ev,
                                                      input logic [7:0] ch);
        tqbp_pkg::t_result r;
        r = blank_event(ev);
        r.entry_type   = pr_type;
        r.weight       = pr_weight;
        r.prefix_flag  = pr_prefix;
        r.operand_char = ch;
        return r;
    endfunction

    function automatic tqbp_pkg::t_result operator_event(input logic [15:0] phrase_gap);
        tqbp_pkg::t_result r;
        r = blank_event(tqbp_pkg::EV_OPERATOR);
        r.entry_type    = pr_type;
        r.operator_code = pr_oper;
        r.distance      = phrase_gap;
        return r;
    endfunction

    // One entry is done; either the next type byte or trailing filler follows.
    task automatic close_entry();
        pr_left  = pr_left - 31'd1;
        pr_phase = (pr_left != 0) ? tqbp_pkg::PH_TYPE : tqbp_pkg::PH_SKIP;
    endtask

    // Advance the parser by one byte and queue the events it produces.
    task automatic parse_byte(input logic [7:0] b);
        tqbp_pkg::t_result evs[$];
        tqbp_pkg::t_result r;
        if (pr_phase == tqbp_pkg::PH_LEN) begin
            // Length word outside any record: no body byte is counted.
            pr_shift    = {pr_shift[23:0], b};
            pr_byte_idx = pr_byte_idx + 2'd1;
            if (pr_byte_idx == 2'd0) begin
                if (pr_shift == tqbp_pkg::NULL_LENGTH) begin
                    evs.push_back(blank_event(tqbp_pkg::EV_NULL));
                end else if (pr_shift[31] || pr_shift < tqbp_pkg::MIN_LENGTH) begin
                    evs.push_back(blank_event(tqbp_pkg::EV_MALFORMED));
                end else begin
                    pr_rec_len  = pr_shift;
                    pr_consumed = '0;
                    pr_phase    = tqbp_pkg::PH_COUNT;
                end
                pr_shift = '0;
            end
        end else begin
            pr_consumed = pr_consumed + 32'd1;
            case (pr_phase)
                tqbp_pkg::PH_COUNT: begin
                    pr_shift    = {pr_shift[23:0], b};
                    pr_byte_idx = pr_byte_idx + 2'd1;
                    if (pr_byte_idx == 2'd0) begin
                        if (pr_shift[31]) begin
                            // A negative count abandons the record on the spot.
                            evs.push_back(blank_event(tqbp_pkg::EV_MALFORMED));
                            pr_phase = tqbp_pkg::PH_LEN;
                        end else begin
                            pr_left = pr_shift[30:0];
                            r = blank_event(tqbp_pkg::EV_START);
                            r.entry_count = pr_left;
                            evs.push_back(r);
                            pr_phase = (pr_left != 0) ? tqbp_pkg::PH_TYPE
                                                      : tqbp_pkg::PH_SKIP;
                        end
                        pr_shift = '0;
                    end
                end
                tqbp_pkg::PH_TYPE: begin
                    pr_type = b;
                    if (b == tqbp_pkg::QI_VAL) begin
                        pr_phase = tqbp_pkg::PH_WEIGHT;
                    end else if (b == tqbp_pkg::QI_OPR) begin
                        pr_phase = tqbp_pkg::PH_OPER;
                    end else begin
                        r = blank_event(tqbp_pkg::EV_OTHER);
                        r.entry_type = b;
                        evs.push_back(r);
                        close_entry();
                    end
                end
                tqbp_pkg::PH_WEIGHT: begin
                    pr_weight = b;
                    pr_phase  = tqbp_pkg::PH_PREFIX;
                end
                tqbp_pkg::PH_PREFIX: begin
                    pr_prefix = b;
                    pr_phase  = tqbp_pkg::PH_OPERAND;
                end
                tqbp_pkg::PH_OPERAND: begin
                    if (b != 8'd0) begin
                        evs.push_back(value_event(tqbp_pkg::EV_CHAR, b));
                    end else begin
                        evs.push_back(value_event(tqbp_pkg::EV_VALUE_END, 8'd0));
                        close_entry();
                    end
                end
                tqbp_pkg::PH_OPER: begin
                    pr_oper = b;
                    if (b == tqbp_pkg::OPC_PHRASE) begin
                        pr_phase = tqbp_pkg::PH_DHI;
                    end else begin
                        evs.push_back(operator_event(16'd0));
                        close_entry();
                    end
                end
                tqbp_pkg::PH_DHI: begin
                    pr_dist_hi = b;
                    pr_phase   = tqbp_pkg::PH_DLO;
                end
                tqbp_pkg::PH_DLO: begin
                    evs.push_back(operator_event({pr_dist_hi, b}));
                    close_entry();
                end
                default: begin
                end
            endcase
            // The last body byte closes the record, cleanly only if every
            // announced entry was complete.
            if (pr_phase != tqbp_pkg::PH_LEN && pr_consumed == pr_rec_len) begin
                if (pr_phase == tqbp_pkg::PH_SKIP) begin
                    evs.push_back(blank_event(tqbp_pkg::EV_REC_END));
                end else begin
                    evs.push_back(blank_event(tqbp_pkg::EV_MALFORMED));
                end
                pr_phase    = tqbp_pkg::PH_LEN;
                pr_byte_idx = '0;
                pr_shift    = '0;
            end else if (pr_phase == tqbp_pkg::PH_LEN) begin
                pr_byte_idx = '0;
                pr_shift    = '0;
            end
        end
        if (evs.size() != 0) begin
            r = evs.pop_back();
            r.last_of_step = 1'b1;
            evs.push_back(r);
        end
        foreach (evs[i]) want_events.push_back(evs[i]);
    endtask

    // Random gaps on either side, none inside the calm window.
    function automatic bit take_gap();
        return !(cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO) &&
               $urandom_range(99) < IDLE_PCT;
    endfunction

    // Record building: the body collects in rec_body; send_record puts the
    // big-endian length word and the first nbytes of the body on the stream.
    task automatic body_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) rec_body.push_back(w[8*k +: 8]);
    endtask

    task automatic send_record(input logic [31:0] len_word, input int nbytes);
        for (int k = 3; k >= 0; k--) byte_stream.push_back(len_word[8*k +: 8]);
        for (int k = 0; k < nbytes; k++) byte_stream.push_back(rec_body[k]);
        rec_body.delete();
    endtask

    task automatic add_operator(input logic [7:0] op, input logic [15:0] phrase_gap);
        rec_body.push_back(tqbp_pkg::QI_OPR);
        rec_body.push_back(op);
        if (op == tqbp_pkg::OPC_PHRASE) begin
            rec_body.push_back(phrase_gap[15:8]);
            rec_body.push_back(phrase_gap[7:0]);
        end
    endtask

    task automatic add_random_entry();
        int         pick;
        logic [7:0] t;
        pick = $urandom_range(99);
        if (pick < 45) begin
            rec_body.push_back(tqbp_pkg::QI_VAL);
            rec_body.push_back(8'($urandom));
            rec_body.push_back(8'($urandom));
            repeat ($urandom_range(5)) rec_body.push_back(8'($urandom_range(255, 1)));
            rec_body.push_back(8'd0);
        end else if (pick < 80) begin
            add_operator(($urandom_range(1) != 0) ? tqbp_pkg::OPC_PHRASE : 8'($urandom),
                         16'($urandom));
        end else begin
            // Any type byte other than value or operator is a bare entry.
            t = 8'($urandom);
            if (t == tqbp_pkg::QI_VAL || t == tqbp_pkg::QI_OPR) t = ~t;
            rec_body.push_back(t);
        end
    endtask

    // Stimulus, reset and the end of the run.
    initial begin : stimulus
        int          kind;
        int          n;
        int          nb;
        int          cut;
        int          directed_len;
        logic [31:0] len;

        // Directed records: null, both bad-length forms, negative count,
        // the largest count cut off by the record end, zero count, and one
        // clean record holding every entry kind with extreme field values.
        send_record(tqbp_pkg::NULL_LENGTH, 0);
        send_record(32'h8000_0000, 0);
        send_record(tqbp_pkg::MIN_LENGTH - 32'd1, 0);
        body_word(32'hFFFF_FFFF);
        send_record(tqbp_pkg::MIN_LENGTH, 4);
        body_word(32'h7FFF_FFFF);
        send_record(tqbp_pkg::MIN_LENGTH, 4);
        body_word(32'd0);
        send_record(tqbp_pkg::MIN_LENGTH, 4);
        body_word(32'd4);
        rec_body.push_back(tqbp_pkg::QI_VAL);
        rec_body.push_back(8'h00);
        rec_body.push_back(8'hFF);
        rec_body.push_back(8'h01);
        rec_body.push_back(8'hFF);
        rec_body.push_back(8'h00);
        add_operator(8'h03, 16'd0);
        add_operator(tqbp_pkg::OPC_PHRASE, 16'h8000);
        rec_body.push_back(8'hFF);
        rec_body.push_back(8'hA5);     // trailing filler byte
        nb = rec_body.size();
        send_record(nb, nb);
        directed_len = byte_stream.size();

        while (byte_stream.size() < directed_len + RANDOM_BYTES) begin
            kind = $urandom_range(99);
            if (kind < 5) begin
                send_record(tqbp_pkg::NULL_LENGTH, 0);
            end else if (kind < 10) begin
                len = ($urandom_range(1) != 0) ? ($urandom | 32'h8000_0000)
                                               : 32'($urandom_range(3));
                if (len == tqbp_pkg::NULL_LENGTH) len = 32'h8000_0000;
                send_record(len, 0);
            end else if (kind < 15) begin
                // After a negative count the next byte is a new length word,
                // so the rest of the announced body is never sent.
                body_word($urandom | 32'h8000_0000);
                send_record(($urandom_range(1) != 0) ? {1'b0, 31'($urandom)}
                                                     : 32'($urandom_range(5000, 4)), 4);
            end else if (kind < 25) begin
                // Framed noise: a sane count word, then arbitrary body bytes.
                nb = $urandom_range(24, 4);
                body_word(($urandom_range(1) != 0) ? {1'b0, 31'($urandom)}
                                                   : 32'($urandom_range(5)));
                while (rec_body.size() < nb) rec_body.push_back(8'($urandom));
                send_record(nb, nb);
            end else begin
                // Well-formed entries; two in fifteen of these records cut short by the length.
                n = $urandom_range(6);
                if (kind < 35 && n == 0) n = 1;
                body_word(n);
                repeat (n) add_random_entry();
                if (kind >= 35) begin
                    repeat ($urandom_range(3)) rec_body.push_back(8'($urandom));
                end
                nb = rec_body.size();
                cut = (kind < 35) ? $urandom_range(nb - 1, 4) : nb;
                send_record(cut, cut);
            end
        end
        total_bytes = byte_stream.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_accepted != total_bytes) @(posedge i_clk);
        while (want_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Driver: an item is taken when tvalid and tready meet at an edge; the
    // parser model sees it then, and the next byte (or a gap) is set up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            pr_phase      = tqbp_pkg::PH_LEN;
            pr_byte_idx   = '0;
            pr_rec_len    = '0;
            pr_consumed   = '0;
            pr_shift      = '0;
            pr_left       = '0;
            pr_type       = '0;
            pr_weight     = '0;
            pr_prefix     = '0;
            pr_oper       = '0;
            pr_dist_hi    = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_stream.size() != 0 && !take_gap()) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_stream.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver stall while the sender keeps offering, so the
    // result queue fills and the block must drop s_axis_tready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: each accepted result is matched against the oldest event owed.
    always @(posedge i_clk) begin : result_check
        tqbp_pkg::t_result want;
        logic              bad;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_events.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("result with none expected: event %0d data %h last %b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want = want_events.pop_front();
                    bad  = (m_axis_tuser         !== want.event_res)     ||
                           (m_axis_tdata[30:0]   !== want.entry_count)   ||
                           (m_axis_tdata[38:31]  !== want.entry_type)    ||
                           (m_axis_tdata[46:39]  !== want.weight)        ||
                           (m_axis_tdata[54:47]  !== want.prefix_flag)   ||
                           (m_axis_tdata[62:55]  !== want.operand_char)  ||
                           (m_axis_tdata[70:63]  !== want.operator_code) ||
                           (m_axis_tdata[86:71]  !== want.distance)      ||
                           (m_axis_tlast         !== want.last_of_step);
                    if (bad) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("mismatch at %0t:", $realtime);
                            $display("    expected ev %0d cnt %h ty %h w %h p %h",
                                     want.event_res, want.entry_count,
                                     want.entry_type, want.weight, want.prefix_flag);
                            $display("             ch %h op %h d %h l %b",
                                     want.operand_char, want.operator_code,
                                     want.distance, want.last_of_step);
                            $display("    actual   ev %0d cnt %h ty %h w %h p %h",
                                     m_axis_tuser, m_axis_tdata[30:0],
                                     m_axis_tdata[38:31], m_axis_tdata[46:39],
                                     m_axis_tdata[54:47]);
                            $display("             ch %h op %h d %h l %b",
                                     m_axis_tdata[62:55], m_axis_tdata[70:63],
                                     m_axis_tdata[86:71], m_axis_tlast);
                        end
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && !take_gap();
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

// ----- files.f -----
hw/rtl/tqbp_pkg.sv
hw/rtl/tqbp_parser.sv
hw/rtl/tqbp_out_queue.sv
hw/rtl/text_query_binary_parser.sv
tb/text_query_binary_parser_tb.sv
